[design/hrsc_pkg.sv]
// ----------------------------------------------------------------------------
// hrsc_pkg
// Types, codes and reset values shared by the ramped speed control unit.
// ----------------------------------------------------------------------------
package hrsc_pkg;

	localparam int MOTOR_COUNT_DEF = 2;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [7:0]  RAMP_STEP_RST     = 8'd5;
	localparam logic [15:0] RAMP_INTERVAL_RST = 16'd10;
	localparam logic [7:0]  MAX_PWM_RST       = 8'd255;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;

	typedef enum logic [1:0] {
		REG_RAMP_STEP     = 2'd0,
		REG_RAMP_INTERVAL = 2'd1,
		REG_MAX_PWM       = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SPEED  = 2'd1,
		OP_CMD    = 2'd2,
		OP_ENABLE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_STEP   = 2'd0,
		CMD_TARGET = 2'd1,
		CMD_ENABLE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [2:0]        motor;
		logic signed [8:0] value;
		logic              flag;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  ramp_step;
		logic [15:0] ramp_interval;
		logic [7:0]  max_pwm;
	} cfg_t;

endpackage

[design/hbridge_ramped_speed_control_unit.sv]
// ----------------------------------------------------------------------------
// hbridge_ramped_speed_control_unit
// Ramped speed control for a bank of H-bridge motors.
//
//  channel  | dir | signals                    | beat
//  s_axis   | in  | tvalid tready tdata tuser  | one request, tuser = op
//  m_axis   | out | tvalid tready tdata tlast  | one motor status, tlast on last
//  apb      | in  | psel penable pwrite paddr  | register write or read
//
// Set-speed, set-command and ticks that do not reach the interval produce
// no beats. A ramp step or an enable change emits one beat per motor in
// the back, which takes no new command until its last beat is issued.
// The four-entry queue lets the front keep accepting while the back emits.
// Reset is asynchronous; registers return to 5, 10, 255 and driver enabled.
// ----------------------------------------------------------------------------
module hbridge_ramped_speed_control_unit import hrsc_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// motor[2:0] speed[18:3] direction[20:19] magnitude[28:21] enable_flag[29]
	input  logic [31:0] s_axis_tdata,
	// op[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// motor_index[2:0] pin_a[3] pin_b[4] duty[12:5] standby_pin[13]
	// current_speed[22:14] target_speed[31:23]
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t              cfg_q;
	logic              cfg_we;
	logic              q_push;
	cmd_t              q_cmd;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	cmd_t              q_head;
	logic [2:0]        o_motor;
	logic              o_pin_a;
	logic              o_pin_b;
	logic [7:0]        o_duty;
	logic              o_standby;
	logic signed [8:0] o_cur;
	logic signed [8:0] o_tgt;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step     <= RAMP_STEP_RST;
			cfg_q.ramp_interval <= RAMP_INTERVAL_RST;
			cfg_q.max_pwm       <= MAX_PWM_RST;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_RAMP_STEP:     cfg_q.ramp_step     <= pwdata[7:0];
				REG_RAMP_INTERVAL: cfg_q.ramp_interval <= pwdata[15:0];
				REG_MAX_PWM:       cfg_q.max_pwm       <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RAMP_STEP:     prdata = {24'd0, cfg_q.ramp_step};
			REG_RAMP_INTERVAL: prdata = {16'd0, cfg_q.ramp_interval};
			REG_MAX_PWM:       prdata = {24'd0, cfg_q.max_pwm};
			default:           prdata = '0;
		endcase
	end

	hrsc_front #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_op         (s_axis_tuser),
		.in_motor      (s_axis_tdata[2:0]),
		.in_speed      (s_axis_tdata[18:3]),
		.in_direction  (s_axis_tdata[20:19]),
		.in_magnitude  (s_axis_tdata[28:21]),
		.in_enable_flag(s_axis_tdata[29]),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	hrsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	hrsc_back #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_motor_index  (o_motor),
		.out_pin_a        (o_pin_a),
		.out_pin_b        (o_pin_b),
		.out_duty         (o_duty),
		.out_standby_pin  (o_standby),
		.out_current_speed(o_cur),
		.out_target_speed (o_tgt),
		.out_last         (m_axis_tlast)
	);

	assign m_axis_tdata = {o_tgt, o_cur, o_standby, o_duty, o_pin_b, o_pin_a, o_motor};

	a_last_on_final_motor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'(MOTOR_COUNT - 1))))
		else $error("tlast not on final motor");

	a_standby_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[13]) |-> (m_axis_tdata[12:0] & 13'h1FF8) == 13'd0)
		else $error("outputs active while driver disabled");

	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
		else $error("both bridge pins high");

	a_duty_matches_pins: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[12:5] == 8'd0) == !(m_axis_tdata[3] || m_axis_tdata[4])))
		else $error("duty and bridge pins disagree");

endmodule

[design/hrsc_front.sv]
// ----------------------------------------------------------------------------
// hrsc_front
// Accepts input beats, counts ms ticks, clamps targets and queues commands.
// ----------------------------------------------------------------------------
module hrsc_front import hrsc_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_op,
	input  logic [2:0]  in_motor,
	input  logic [15:0] in_speed,
	input  logic [1:0]  in_direction,
	input  logic [7:0]  in_magnitude,
	input  logic        in_enable_flag,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic [15:0]        ticks_q;
	logic [15:0]        ticks_inc;
	logic               step_hit;
	logic               accept;
	logic               motor_ok;
	logic signed [16:0] lim;
	logic signed [16:0] req;
	logic signed [16:0] clamped;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign ticks_inc = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
	assign step_hit  = ticks_inc >= cfg.ramp_interval;
	assign motor_ok  = {1'b0, in_motor} < 4'(MOTOR_COUNT);
	assign lim       = $signed({9'd0, cfg.max_pwm});

	always_comb begin
		if (op_t'(in_op) == OP_SPEED) begin
			req = {in_speed[15], in_speed};
		end else if (in_direction == DIR_STOP || in_magnitude == 8'd0) begin
			req = '0;
		end else if (in_direction == DIR_FWD) begin
			req = $signed({9'd0, in_magnitude});
		end else begin
			req = -$signed({9'd0, in_magnitude});
		end
		if (req > lim) begin
			clamped = lim;
		end else if (req < -lim) begin
			clamped = -lim;
		end else begin
			clamped = req;
		end
	end

	always_comb begin
		q_cmd.motor = in_motor;
		q_cmd.value = 9'(clamped);
		q_cmd.flag  = in_enable_flag;
		q_cmd.kind  = CMD_TARGET;
		q_push      = 1'b0;
		unique case (op_t'(in_op))
			OP_TICK: begin
				q_cmd.kind = CMD_STEP;
				q_push     = accept && step_hit;
			end
			OP_SPEED, OP_CMD: begin
				q_cmd.kind = CMD_TARGET;
				q_push     = accept && motor_ok;
			end
			OP_ENABLE: begin
				q_cmd.kind = CMD_ENABLE;
				q_push     = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (accept && op_t'(in_op) == OP_TICK) begin
			ticks_q <= step_hit ? 16'd0 : ticks_inc;
		end
	end

endmodule

[design/hrsc_queue.sv]
// ----------------------------------------------------------------------------
// hrsc_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module hrsc_queue import hrsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full   = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign valid  = count_q != '0;
	assign head   = mem_q[rptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/hrsc_back.sv]
// ----------------------------------------------------------------------------
// hrsc_back
// Holds motor state, runs ramp steps and enable changes, emits result beats.
// ----------------------------------------------------------------------------
module hrsc_back import hrsc_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  cmd_t              q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_motor_index,
	output logic              out_pin_a,
	output logic              out_pin_b,
	output logic [7:0]        out_duty,
	output logic              out_standby_pin,
	output logic signed [8:0] out_current_speed,
	output logic signed [8:0] out_target_speed,
	output logic              out_last
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       pin_a;
		logic       pin_b;
		logic [7:0] duty;
	} app_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic              enabled_q;
	logic signed [8:0] cur_q [MOTOR_COUNT];
	logic signed [8:0] tgt_q [MOTOR_COUNT];
	app_t              app_q [MOTOR_COUNT];

	logic signed [8:0]  cur;
	logic signed [8:0]  goal;
	logic signed [10:0] up;
	logic signed [10:0] dn;
	logic signed [8:0]  nv;
	logic signed [8:0]  mag9;
	app_t               drv;
	logic signed [8:0]  res_cur;
	app_t               res_app;
	logic               slot_free;
	logic               is_last;
	logic [IDX_W-1:0]   tmotor;

	assign cur       = cur_q[idx_q];
	assign goal      = tgt_q[idx_q];
	assign up        = 11'(cur) + $signed({3'd0, cfg.ramp_step});
	assign dn        = 11'(cur) - $signed({3'd0, cfg.ramp_step});
	assign slot_free = !out_valid || out_ready;
	assign is_last   = idx_q == IDX_W'(MOTOR_COUNT - 1);
	assign q_pop     = state_q == ST_IDLE && q_valid;
	assign tmotor    = q_head.motor[IDX_W-1:0];

	always_comb begin
		if (cur < goal) begin
			nv = (up > 11'(goal)) ? goal : 9'(up);
		end else if (cur > goal) begin
			nv = (dn < 11'(goal)) ? goal : 9'(dn);
		end else begin
			nv = cur;
		end
		mag9 = (nv < 0) ? -nv : nv;
		if (!enabled_q || nv == 9'sd0) begin
			drv = '0;
		end else begin
			drv.pin_a = nv > 0;
			drv.pin_b = nv < 0;
			drv.duty  = mag9[7:0];
		end
		res_cur = (state_q == ST_STEP) ? nv : cur;
		res_app = (state_q == ST_STEP) ? drv : app_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			enabled_q <= 1'b1;
			out_valid <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
				app_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (q_valid) begin
						unique case (q_head.kind)
							CMD_STEP: begin
								state_q <= ST_STEP;
							end
							CMD_TARGET: begin
								tgt_q[tmotor] <= q_head.value;
							end
							CMD_ENABLE: begin
								enabled_q <= q_head.flag;
								if (!q_head.flag) begin
									for (int i = 0; i < MOTOR_COUNT; i++) begin
										cur_q[i] <= '0;
										app_q[i] <= '0;
									end
								end
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_STEP, ST_EMIT: begin
					if (slot_free) begin
						cur_q[idx_q]      <= res_cur;
						app_q[idx_q]      <= res_app;
						out_valid         <= 1'b1;
						out_motor_index   <= 3'(idx_q);
						out_pin_a         <= res_app.pin_a;
						out_pin_b         <= res_app.pin_b;
						out_duty          <= res_app.duty;
						out_standby_pin   <= enabled_q;
						out_current_speed <= res_cur;
						out_target_speed  <= goal;
						out_last          <= is_last;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
